>>> src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned PRIO_W       = 32;
    localparam int unsigned ENTRY_W      = DATA_W + PRIO_W;
    localparam int unsigned COUNT_W      = 9;

    // Request codes
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_MODIFY  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

>>> src/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Binary max-heap priority queue of (data, priority) entries.
// ----------------------------------------------------------------------------
// One request in, one result out. The heap lives in a single-port RAM with
// registered read data, and the sequencer does at most one RAM access a
// cycle. Insert: per level climbed, read the parent, then compare and move
// the parent down, until the parent is not lower or the root is reached.
// Extract: setup reads the root, reads the last entry and takes it, then
// per level descended reads the left child, reads the right child, then
// compares and moves one child up. Modify: one read a cycle over the
// entries, the match or the miss seen in the cycle after the last read,
// then a sift as above. Every request ends with the final write, top read,
// top capture and result load; full, empty, not found and the unused code
// skip the final write and go to the top read after the search or at once.
// A result waits in an output register while the next request runs; that
// request's result waits in place until the register is handed off.
// Reset needs no clearing pass.
module binary_max_heap_queue_top
    import bmhq_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic signed [bmhq_pkg::DATA_W-1:0]  s_item_data,
    input  logic signed [bmhq_pkg::PRIO_W-1:0]  s_item_priority,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic signed [bmhq_pkg::DATA_W-1:0]  m_extracted_data,
    output logic [bmhq_pkg::COUNT_W-1:0]        m_entry_count,
    output logic                        m_top_valid,
    output logic signed [bmhq_pkg::DATA_W-1:0]  m_top_data
);

    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned PW  = AW + 2;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPRD   = 4'd1;
    localparam logic [3:0] S_UPCMP  = 4'd2;
    localparam logic [3:0] S_UPWR   = 4'd3;
    localparam logic [3:0] S_DNRDL  = 4'd4;
    localparam logic [3:0] S_DNRDR  = 4'd5;
    localparam logic [3:0] S_DNCMP  = 4'd6;
    localparam logic [3:0] S_DNWR   = 4'd7;
    localparam logic [3:0] S_EXRT   = 4'd8;
    localparam logic [3:0] S_EXLAST = 4'd9;
    localparam logic [3:0] S_SRCH   = 4'd10;
    localparam logic [3:0] S_TOPRD  = 4'd11;
    localparam logic [3:0] S_TOPW   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;
    localparam logic [3:0] S_DNRDLW = 4'd14;
    localparam logic [3:0] S_EXWAIT = 4'd15;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       pos_reg, pos_next;     // node being sifted
    logic [PW-1:0]       scan_reg, scan_next;   // search / other address
    logic [DATA_W-1:0]   cur_d_reg, cur_d_next; // entry being sifted
    logic signed [PRIO_W-1:0] cur_p_reg, cur_p_next;
    logic [ENTRY_W-1:0]  left_reg, left_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [1:0]          st_reg, st_next;
    logic [DATA_W-1:0]   ext_reg, ext_next;
    logic                mv_reg, mv_next;
    logic                srch_pend_reg, srch_pend_next;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    bmhq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic [DATA_W-1:0]        rd_d;
    logic signed [PRIO_W-1:0] rd_p, lf_p;
    logic [PW-1:0]            parent, lchild, rchild;
    logic [PW-1:0]            cnt_ext;

    assign rd_d    = ram_rdata[ENTRY_W-1:PRIO_W];
    assign rd_p    = ram_rdata[PRIO_W-1:0];
    assign lf_p    = left_reg[PRIO_W-1:0];
    assign parent  = (pos_reg - PW'(1)) >> 1;
    assign lchild  = {pos_reg[PW-2:0], 1'b1};
    assign rchild  = {pos_reg[PW-2:0], 1'b0} + PW'(2);
    assign cnt_ext = PW'(count_reg);

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer: one RAM access per cycle
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        cur_d_next     = cur_d_reg;
        cur_p_next     = cur_p_reg;
        left_next      = left_reg;
        key_next       = key_reg;
        st_next        = st_reg;
        ext_next       = ext_reg;
        mv_next        = mv_reg;
        srch_pend_next = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = '0;
        ram_wdata      = {cur_d_reg, cur_p_reg};
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    key_next   = s_item_data;
                    cur_d_next = s_item_data;
                    cur_p_next = s_item_priority;
                    st_next    = ST_OK;
                    ext_next   = '0;
                    case (s_req_type)
                        REQ_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                st_next    = ST_FULL;
                                state_next = S_TOPRD;
                            end else begin
                                pos_next   = cnt_ext;
                                count_next = count_reg + CW'(1);
                                state_next = S_UPRD;
                            end
                        end
                        REQ_EXTRACT: begin
                            if (count_reg == '0) begin
                                st_next    = ST_EMPTY;
                                state_next = S_TOPRD;
                            end else begin
                                state_next = S_EXRT;
                            end
                        end
                        REQ_MODIFY: begin
                            scan_next  = '0;
                            state_next = S_SRCH;
                        end
                        default: begin
                            state_next = S_TOPRD;
                        end
                    endcase
                end
            end
            // climb: read parent unless at root
            S_UPRD: begin
                if (pos_reg == '0) begin
                    state_next = S_UPWR;
                end else begin
                    ram_addr   = AW'(parent);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (cur_p_reg > rd_p) begin
                    // parent moves down
                    ram_we     = 1'b1;
                    ram_addr   = AW'(pos_reg);
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = S_UPRD;
                end else begin
                    state_next = S_UPWR;
                end
            end
            S_UPWR: begin
                ram_we     = 1'b1;
                ram_addr   = AW'(pos_reg);
                state_next = S_TOPRD;
            end
            // extract: read root, then last entry
            S_EXRT: begin
                ram_addr   = '0;
                state_next = S_EXLAST;
            end
            S_EXLAST: begin
                ext_next   = rd_d;
                ram_addr   = AW'(cnt_ext - PW'(1));
                count_next = count_reg - CW'(1);
                state_next = S_EXWAIT;
            end
            S_EXWAIT: begin
                cur_d_next = rd_d;
                cur_p_next = rd_p;
                pos_next   = '0;
                state_next = S_DNRDL;
            end
            // descend: read left child, then right child
            S_DNRDL: begin
                if (lchild >= cnt_ext) begin
                    state_next = S_UPWR;
                end else begin
                    ram_addr   = AW'(lchild);
                    state_next = S_DNRDLW;
                end
            end
            S_DNRDLW: begin
                left_next = ram_rdata;
                if (rchild < cnt_ext) begin
                    ram_addr   = AW'(rchild);
                    state_next = S_DNRDR;
                end else begin
                    state_next = S_DNCMP;
                end
            end
            S_DNRDR: begin
                // right child data valid now
                if (rd_p > lf_p && rd_p > cur_p_reg) begin
                    ram_we     = 1'b1;
                    ram_addr   = AW'(pos_reg);
                    ram_wdata  = ram_rdata;
                    pos_next   = rchild;
                    state_next = S_DNRDL;
                end else begin
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP: begin
                if (lf_p > cur_p_reg) begin
                    ram_we     = 1'b1;
                    ram_addr   = AW'(pos_reg);
                    ram_wdata  = left_reg;
                    pos_next   = lchild;
                    state_next = S_DNRDL;
                end else begin
                    state_next = S_UPWR;
                end
            end
            S_DNWR: begin
                state_next = S_UPWR;
            end
            // linear search, one read per cycle
            S_SRCH: begin
                if (srch_pend_reg && rd_d == key_reg) begin
                    pos_next = scan_reg - PW'(1);
                    cur_d_next = rd_d;
                    if (cur_p_reg > rd_p) begin
                        state_next = S_UPRD;
                    end else if (cur_p_reg < rd_p) begin
                        state_next = S_DNRDL;
                    end else begin
                        state_next = S_UPWR;
                    end
                end else if (scan_reg >= cnt_ext) begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_TOPRD;
                end else begin
                    ram_addr       = AW'(scan_reg);
                    scan_next      = scan_reg + PW'(1);
                    srch_pend_next = 1'b1;
                end
            end
            S_TOPRD: begin
                ram_addr   = '0;
                state_next = S_TOPW;
            end
            S_TOPW: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic [DATA_W-1:0] top_reg, top_next;
    assign top_next = (state_reg == S_TOPW) ? rd_d : top_reg;

    // Result output register, loaded as the result is handed over
    logic                out_load;
    logic [1:0]          out_st_reg;
    logic [DATA_W-1:0]   out_ext_reg;
    logic [COUNT_W-1:0]  out_cnt_reg;
    logic                out_tv_reg;
    logic [DATA_W-1:0]   out_top_reg;

    assign out_load = (state_reg == S_DONE) && !mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mv_reg        <= 1'b0;
            srch_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mv_reg        <= mv_next;
            srch_pend_reg <= srch_pend_next;
        end
        pos_reg   <= pos_next;
        scan_reg  <= scan_next;
        cur_d_reg <= cur_d_next;
        cur_p_reg <= cur_p_next;
        left_reg  <= left_next;
        key_reg   <= key_next;
        st_reg    <= st_next;
        ext_reg   <= ext_next;
        top_reg   <= top_next;
        if (out_load) begin
            out_st_reg  <= st_reg;
            out_ext_reg <= ext_reg;
            out_cnt_reg <= COUNT_W'(count_reg);
            out_tv_reg  <= (count_reg != '0);
            out_top_reg <= (count_reg != '0) ? top_reg : '0;
        end
    end

    assign m_valid          = mv_reg;
    assign m_status         = out_st_reg;
    assign m_extracted_data = out_ext_reg;
    assign m_entry_count    = out_cnt_reg;
    assign m_top_valid      = out_tv_reg;
    assign m_top_data       = out_top_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY)) else $error("count above capacity");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
        && $stable(m_entry_count))) else $error("result changed while stalled");
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_entry_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");
`endif

endmodule
